// File: src/sfi_pkg.sv
package sfi_pkg;

    // Layer geometry.
    localparam int FEATURES       = 128;
    localparam int CLASSES        = 10;
    localparam int WORD_BITS      = 32;
    localparam int STEP_WORDS     = (FEATURES + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W          = $clog2(WORD_BITS);
    localparam int WORD_CNT_W     = (STEP_WORDS > 1) ? $clog2(STEP_WORDS) : 1;
    localparam int FEAT_W         = WORD_CNT_W + BIT_W;
    localparam int FEAT_AW        = $clog2(FEATURES);
    localparam int DATA_W         = 32;
    localparam int STEP_W         = 16;

    // Stream field layout.
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 16;
    localparam int OPCODE_W   = 2;
    localparam int WCLASS_W   = 4;
    localparam int WFEAT_W    = 7;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WEIGHT = 2'd0,
        OP_SPIKE  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 1'd0,
        CFG_STEPS     = 1'd1
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DRAIN,
        ST_FIRE_ADD,
        ST_FIRE_CMP,
        ST_EMIT
    } t_state;

    // Per-cycle command broadcast to every class lane.
    typedef struct packed {
        logic clear;
        logic acc;
        logic fire_add;
        logic fire_cmp;
    } t_lane_ctrl;

endpackage

// File: src/sfi_lane.sv
module sfi_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [sfi_pkg::FEAT_AW-1:0]      i_wr_addr,
    input  logic [sfi_pkg::DATA_W-1:0]       i_wr_data,
    input  logic [sfi_pkg::FEAT_AW-1:0]      i_rd_addr,
    input  sfi_pkg::t_lane_ctrl              i_ctrl,
    input  logic [sfi_pkg::DATA_W-1:0]       i_threshold,
    output logic                             o_fire
);

    // One weight column per class lane: this lane's weight for every feature.
    logic [sfi_pkg::DATA_W-1:0] r_mem [sfi_pkg::FEATURES];
    logic [sfi_pkg::DATA_W-1:0] r_rd_data;
    logic [sfi_pkg::DATA_W-1:0] r_step_sum, n_step_sum;
    logic [sfi_pkg::DATA_W-1:0] r_membrane, n_membrane;
    logic                       r_fire, n_fire;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_comb begin
        n_step_sum = r_step_sum;
        n_membrane = r_membrane;
        n_fire     = r_fire;
        if (i_ctrl.clear) begin
            n_step_sum = '0;
            n_membrane = '0;
        end else if (i_ctrl.acc) begin
            n_step_sum = r_step_sum + r_rd_data;
        end else if (i_ctrl.fire_add) begin
            n_membrane = r_membrane + r_step_sum;
            n_step_sum = '0;
        end else if (i_ctrl.fire_cmp) begin
            n_fire = ($signed(r_membrane) >= $signed(i_threshold));
            if (n_fire) begin
                n_membrane = r_membrane - i_threshold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_sum <= '0;
            r_membrane <= '0;
            r_fire     <= 1'b0;
        end else begin
            r_step_sum <= n_step_sum;
            r_membrane <= n_membrane;
            r_fire     <= n_fire;
        end
    end

    assign o_fire = r_fire;

endmodule

// File: src/spiking_fc_integrate_fire_unit.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata: spike, weight fields; tuser: opcode
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata: fire_mask; tlast: inference_last
// cfg       in         i_cfg_we (no back-pressure)     i_cfg_index, i_cfg_wdata
//
// A weight write, a clear or an unused opcode is handled as it is accepted. A spike word is
// accepted, then walks its feature bits (one weight read per bit in every lane) and drains
// the read pipeline; the last word of a timestep then goes on to the membrane update, the
// threshold compare and the load of the output register. Reset is synchronous,
// active low, and clears membranes, sums and counters; weights are undefined until written.
// A result waits in the output register; only the next result that finds it full stalls.
module spiking_fc_integrate_fire_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata from bit 0: spike_bits[31:0], weight_class[35:32], weight_feature[42:36],
    // weight_value[74:43], zero padding[79:75].
    input  logic [sfi_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // tuser: opcode[1:0].
    input  logic [sfi_pkg::OPCODE_W-1:0]       i_s_axis_tuser,
    // Output stream.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata from bit 0: fire_mask[9:0], zero padding[15:10].
    output logic [sfi_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [sfi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sfi_pkg::DATA_W-1:0]         i_cfg_wdata
);

    // Unpacked request fields.
    logic [sfi_pkg::WORD_BITS-1:0] w_spike_bits;
    logic [sfi_pkg::WCLASS_W-1:0]  w_wclass;
    logic [sfi_pkg::WFEAT_W-1:0]   w_wfeat;
    logic [sfi_pkg::DATA_W-1:0]    w_wvalue;
    logic                          w_accept;

    assign w_spike_bits = i_s_axis_tdata[31:0];
    assign w_wclass     = i_s_axis_tdata[35:32];
    assign w_wfeat      = i_s_axis_tdata[42:36];
    assign w_wvalue     = i_s_axis_tdata[74:43];
    assign w_accept     = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration registers.
    logic [sfi_pkg::DATA_W-1:0] r_threshold;
    logic [sfi_pkg::STEP_W-1:0] r_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= sfi_pkg::DATA_W'(1);
            r_steps     <= sfi_pkg::STEP_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfi_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_wdata;
                sfi_pkg::CFG_STEPS:     r_steps     <= i_cfg_wdata[sfi_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state.
    sfi_pkg::t_state                r_state, n_state;
    logic [sfi_pkg::WORD_BITS-1:0]  r_bits, n_bits;
    logic [sfi_pkg::BIT_W-1:0]      r_bit, n_bit;
    logic [sfi_pkg::WORD_CNT_W-1:0] r_word, n_word;
    logic [sfi_pkg::STEP_W-1:0]     r_step_cnt, n_step_cnt;
    logic                           r_acc_v, n_acc_v;
    logic                           r_out_valid, n_out_valid;
    logic [sfi_pkg::CLASSES-1:0]    r_out_mask, n_out_mask;
    logic                           r_out_last, n_out_last;

    logic [sfi_pkg::FEAT_W-1:0]     w_feat;
    logic                           w_word_end;
    logic                           w_step_last;
    logic                           w_out_free;
    logic [sfi_pkg::CLASSES-1:0]    w_fire;
    sfi_pkg::t_lane_ctrl            w_ctrl;

    // The feature addressed in this cycle of a spike word.
    assign w_feat      = {r_word, r_bit};
    assign w_word_end  = (r_word == sfi_pkg::WORD_CNT_W'(sfi_pkg::STEP_WORDS - 1));
    assign w_step_last = ({1'b0, r_step_cnt} + (sfi_pkg::STEP_W + 1)'(1)) >= {1'b0, r_steps};
    assign w_out_free  = !r_out_valid || i_m_axis_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfi_pkg::ST_IDLE: begin
                if (w_accept && (i_s_axis_tuser == sfi_pkg::OP_SPIKE)) begin
                    n_state = sfi_pkg::ST_ACCUM;
                end
            end
            sfi_pkg::ST_ACCUM: begin
                if (r_bit == sfi_pkg::BIT_W'(sfi_pkg::WORD_BITS - 1)) begin
                    n_state = sfi_pkg::ST_DRAIN;
                end
            end
            sfi_pkg::ST_DRAIN: begin
                n_state = w_word_end ? sfi_pkg::ST_FIRE_ADD : sfi_pkg::ST_IDLE;
            end
            sfi_pkg::ST_FIRE_ADD: n_state = sfi_pkg::ST_FIRE_CMP;
            sfi_pkg::ST_FIRE_CMP: n_state = sfi_pkg::ST_EMIT;
            sfi_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = sfi_pkg::ST_IDLE;
                end
            end
            default: n_state = sfi_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: lane commands, counters and the output register.
    always_comb begin
        o_s_axis_tready = (r_state == sfi_pkg::ST_IDLE);
        w_ctrl          = '0;
        w_ctrl.acc      = r_acc_v;
        n_bits          = r_bits;
        n_bit           = r_bit;
        n_word          = r_word;
        n_step_cnt      = r_step_cnt;
        n_acc_v         = 1'b0;
        n_out_valid     = r_out_valid && !i_m_axis_tready;
        n_out_mask      = r_out_mask;
        n_out_last      = r_out_last;
        case (r_state)
            sfi_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_axis_tuser == sfi_pkg::OP_SPIKE) begin
                        n_bits = w_spike_bits;
                        n_bit  = '0;
                    end else if (i_s_axis_tuser == sfi_pkg::OP_CLEAR) begin
                        w_ctrl.clear = 1'b1;
                        n_word       = '0;
                        n_step_cnt   = '0;
                    end
                end
            end
            sfi_pkg::ST_ACCUM: begin
                // The weight read for this bit returns next cycle, with its add flag.
                n_acc_v = r_bits[0]
                       && ({1'b0, w_feat} < (sfi_pkg::FEAT_W + 1)'(sfi_pkg::FEATURES));
                n_bits  = r_bits >> 1;
                n_bit   = r_bit + sfi_pkg::BIT_W'(1);
            end
            sfi_pkg::ST_DRAIN: begin
                n_word = w_word_end ? '0 : r_word + sfi_pkg::WORD_CNT_W'(1);
            end
            sfi_pkg::ST_FIRE_ADD: w_ctrl.fire_add = 1'b1;
            sfi_pkg::ST_FIRE_CMP: w_ctrl.fire_cmp = 1'b1;
            sfi_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_mask  = w_fire;
                    n_out_last  = w_step_last;
                    n_step_cnt  = w_step_last ? '0 : r_step_cnt + sfi_pkg::STEP_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfi_pkg::ST_IDLE;
            r_bit       <= '0;
            r_word      <= '0;
            r_step_cnt  <= '0;
            r_acc_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_word      <= n_word;
            r_step_cnt  <= n_step_cnt;
            r_acc_v     <= n_acc_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits     <= n_bits;
        r_out_mask <= n_out_mask;
        r_out_last <= n_out_last;
    end

    // One lane per class. Each lane owns its weight column, accumulator and membrane;
    // every lane sees the same feature address and command each cycle.
    for (genvar c = 0; c < sfi_pkg::CLASSES; c++) begin : g_lane
        logic w_wr_en;

        assign w_wr_en = w_accept && (i_s_axis_tuser == sfi_pkg::OP_WEIGHT)
                      && (w_wclass == sfi_pkg::WCLASS_W'(c))
                      && ({1'b0, w_wfeat} < (sfi_pkg::WFEAT_W + 1)'(sfi_pkg::FEATURES));

        sfi_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (w_wr_en),
            .i_wr_addr   (sfi_pkg::FEAT_AW'(w_wfeat)),
            .i_wr_data   (w_wvalue),
            .i_rd_addr   (sfi_pkg::FEAT_AW'(w_feat)),
            .i_ctrl      (w_ctrl),
            .i_threshold (r_threshold),
            .o_fire      (w_fire[c])
        );
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = sfi_pkg::M_TDATA_W'(r_out_mask);
    assign o_m_axis_tlast  = r_out_last;

endmodule

// File: tb/spiking_fc_integrate_fire_unit_tb.sv
`timescale 1ns / 1ps

module spiking_fc_integrate_fire_unit_tb;

    // Opcode 3 is not decoded by the block; it must be swallowed without effect.
    localparam logic [sfi_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // The settle time covers any request that is still being worked on, including the extra
    // work that follows the last spike word of a timestep.
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MIX_ITEMS     = 36;
    localparam int PHASES        = 9;

    // Bit positions within a spike word whose features get weights. Spike words only
    // ever set these bits, since a weight holds nothing defined until written.
    localparam logic [31:0] SPIKE_FEATURES = 32'hC001_8003;

    // One request on the input stream, held field by field.
    typedef struct {
        logic [sfi_pkg::OPCODE_W-1:0] opcode;
        logic [31:0]                  spikes;
        logic [sfi_pkg::WCLASS_W-1:0] wclass;
        logic [sfi_pkg::WFEAT_W-1:0]  wfeat;
        logic [31:0]                  wval;
    } t_layer_req;

    // One fire mask as the block should emit it.
    typedef struct {
        logic [sfi_pkg::CLASSES-1:0] mask;
        logic                        last;
    } t_fire_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic [sfi_pkg::S_TDATA_W-1:0] req_data = '0;
    logic [sfi_pkg::OPCODE_W-1:0]  req_user = '0;
    logic                          res_ready = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [sfi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sfi_pkg::DATA_W-1:0]    cfg_wdata = '0;
    wire                           req_ready;
    wire                           res_valid;
    wire [sfi_pkg::M_TDATA_W-1:0]  res_data;
    wire                           res_last;

    // Both sides throttle at random while this is set.
    logic idle_enable = 1'b1;
    int   cycle_count = 0;
    int   error_count = 0;

    t_layer_req   req_queue[$];
    t_layer_req   req_in_flight;
    t_fire_result fire_expect_q[$];

    // Mirror of the layer: weights, membranes, per-step sums, counters, registers.
    logic signed [31:0] weight_mem [sfi_pkg::CLASSES][sfi_pkg::FEATURES];
    logic signed [31:0] membrane_pot [sfi_pkg::CLASSES];
    logic signed [31:0] step_acc [sfi_pkg::CLASSES];
    int                 word_idx = 0;
    int                 step_idx = 0;
    logic signed [31:0] threshold_reg = 32'sd1;
    logic [sfi_pkg::STEP_W-1:0] steps_reg = 16'd1;

    spiking_fc_integrate_fire_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_user),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tlast  (res_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Applies one accepted request to the mirror. Only the last spike word of a
    // timestep integrates the membranes, fires and queues a fire mask.
    task automatic integrate_and_fire(input t_layer_req req);
        int                          k;
        int                          c;
        int                          feat;
        logic [sfi_pkg::CLASSES-1:0] mask;
        logic                        last_step;
        case (req.opcode)
            sfi_pkg::OP_WEIGHT: begin
                // Writes to a class row past the layer are dropped.
                if (req.wclass < sfi_pkg::CLASSES && req.wfeat < sfi_pkg::FEATURES) begin
                    weight_mem[req.wclass][req.wfeat] = req.wval;
                end
            end
            sfi_pkg::OP_CLEAR: begin
                for (c = 0; c < sfi_pkg::CLASSES; c++) begin
                    membrane_pot[c] = '0;
                    step_acc[c] = '0;
                end
                word_idx = 0;
                step_idx = 0;
            end
            sfi_pkg::OP_SPIKE: begin
                for (k = 0; k < sfi_pkg::WORD_BITS; k++) begin
                    feat = word_idx * sfi_pkg::WORD_BITS + k;
                    if (req.spikes[k] && feat < sfi_pkg::FEATURES) begin
                        for (c = 0; c < sfi_pkg::CLASSES; c++) begin
                            step_acc[c] += weight_mem[c][feat];
                        end
                    end
                end
                if (word_idx + 1 < sfi_pkg::STEP_WORDS) begin
                    word_idx++;
                end else begin
                    word_idx = 0;
                    mask = '0;
                    for (c = 0; c < sfi_pkg::CLASSES; c++) begin
                        membrane_pot[c] += step_acc[c];
                        step_acc[c] = '0;
                        // Soft reset: a firing class keeps the excess above threshold.
                        if (membrane_pot[c] >= threshold_reg) begin
                            mask[c] = 1'b1;
                            membrane_pot[c] -= threshold_reg;
                        end
                    end
                    // A step count of zero behaves like one: every step ends an inference.
                    last_step = (step_idx + 1 >= int'(steps_reg));
                    step_idx = last_step ? 0 : step_idx + 1;
                    fire_expect_q.push_back('{mask, last_step});
                end
            end
            default: begin
            end
        endcase
    endtask

    // Request driver. A new request is loaded only when the current one is taken
    // or none is pending, so tvalid gets exactly one update per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || req_ready) begin
            if (req_valid) begin
                integrate_and_fire(req_in_flight);
            end
            if (req_queue.size() != 0 && !(idle_enable && $urandom_range(99) < 11)) begin
                req_in_flight = req_queue.pop_front();
                req_valid <= 1'b1;
                req_data  <= {5'b0, req_in_flight.wval, req_in_flight.wfeat,
                              req_in_flight.wclass, req_in_flight.spikes};
                req_user  <= req_in_flight.opcode;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure. Each accepted mask is checked
    // against the oldest prediction.
    always @(posedge i_clk) begin
        t_fire_result exp_res;
        res_ready <= !(idle_enable && $urandom_range(99) < 11);
        if (i_rst_n && res_valid && res_ready) begin
            if (fire_expect_q.size() == 0) begin
                $error("unexpected result: fire_mask %h, inference_last %b",
                       res_data[sfi_pkg::CLASSES-1:0], res_last);
                error_count++;
            end else begin
                exp_res = fire_expect_q.pop_front();
                if (res_data[sfi_pkg::CLASSES-1:0] !== exp_res.mask) begin
                    $error("fire_mask mismatch: expected %h, got %h",
                           exp_res.mask, res_data[sfi_pkg::CLASSES-1:0]);
                    error_count++;
                end
                if (res_last !== exp_res.last) begin
                    $error("inference_last mismatch: expected %b, got %b",
                           exp_res.last, res_last);
                    error_count++;
                end
            end
        end
    end

    // Class and feature arrive at full width and are cut to their field widths here.
    task automatic queue_request(input logic [sfi_pkg::OPCODE_W-1:0] op,
                                 input logic [31:0] spikes, input logic [31:0] wclass,
                                 input logic [31:0] wfeat, input logic [31:0] wval);
        req_queue.push_back('{op, spikes, sfi_pkg::WCLASS_W'(wclass),
                              sfi_pkg::WFEAT_W'(wfeat), wval});
    endtask

    // One timestep worth of spike words, lowest features first. Unused fields carry noise.
    task automatic queue_words(input logic [31:0] w0, input logic [31:0] w1,
                               input logic [31:0] w2, input logic [31:0] w3);
        queue_request(sfi_pkg::OP_SPIKE, w0, $urandom, $urandom, $urandom);
        queue_request(sfi_pkg::OP_SPIKE, w1, $urandom, $urandom, $urandom);
        queue_request(sfi_pkg::OP_SPIKE, w2, $urandom, $urandom, $urandom);
        queue_request(sfi_pkg::OP_SPIKE, w3, $urandom, $urandom, $urandom);
    endtask

    // Mostly small weights so that thresholds matter; now and then a full-range one.
    function automatic logic [31:0] weight_value();
        if ($urandom_range(9) == 0) begin
            return $urandom;
        end
        return $urandom_range(320) - 96;
    endfunction

    // Spike densities from silent to saturated, kept to the features that have weights.
    function automatic logic [31:0] spike_pattern();
        logic [31:0] pat;
        case ($urandom_range(5))
            0: pat = '0;
            1: pat = '1;
            2: pat = $urandom & $urandom;
            3: pat = $urandom | $urandom;
            default: pat = $urandom;
        endcase
        return pat & SPIKE_FEATURES;
    endfunction

    // Random traffic: mostly whole timesteps, plus weight updates, clears, steps broken
    // off by a clear, and requests the block drops (these do not count).
    task automatic queue_random_mix(input int count);
        int pushed;
        int pick;
        pushed = 0;
        while (pushed < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                queue_words(spike_pattern(), spike_pattern(), spike_pattern(), spike_pattern());
                pushed += sfi_pkg::STEP_WORDS;
            end else if (pick < 82) begin
                queue_request(sfi_pkg::OP_WEIGHT, $urandom,
                              $urandom_range(sfi_pkg::CLASSES - 1), $urandom, weight_value());
                pushed++;
            end else if (pick < 88) begin
                repeat ($urandom_range(1, sfi_pkg::STEP_WORDS - 1)) begin
                    queue_request(sfi_pkg::OP_SPIKE, spike_pattern(), $urandom, $urandom,
                                  $urandom);
                    pushed++;
                end
                queue_request(sfi_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
                pushed++;
            end else if (pick < 92) begin
                queue_request(sfi_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
                pushed++;
            end else if (pick < 96) begin
                queue_request(sfi_pkg::OP_WEIGHT, $urandom,
                              $urandom_range(15, sfi_pkg::CLASSES), $urandom, $urandom);
            end else begin
                queue_request(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    // Waits until every queued request is taken and every predicted mask has come
    // back, then lets the given number of cycles pass.
    task automatic wait_for_results(input int settle);
        while (req_queue.size() != 0 || req_valid || fire_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle, so the mirror updates at once.
    task automatic write_config(input sfi_pkg::t_cfg_index idx,
                                input logic [sfi_pkg::DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            sfi_pkg::CFG_THRESHOLD: threshold_reg = value;
            sfi_pkg::CFG_STEPS:     steps_reg = value[sfi_pkg::STEP_W-1:0];
            default: begin
            end
        endcase
    endtask

    initial begin
        logic [31:0] thr;
        logic [31:0] steps;
        int          p;
        int          c;
        int          f;

        // Membranes and step sums start at zero, as after reset.
        for (c = 0; c < sfi_pkg::CLASSES; c++) begin
            membrane_pot[c] = '0;
            step_acc[c] = '0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every feature that a spike word can name gets a weight in each class before
        // the first spike word.
        for (c = 0; c < sfi_pkg::CLASSES; c++) begin
            for (f = 0; f < sfi_pkg::FEATURES; f++) begin
                if (SPIKE_FEATURES[f % sfi_pkg::WORD_BITS]) begin
                    queue_request(sfi_pkg::OP_WEIGHT, $urandom, c, f, weight_value());
                end
            end
        end

        // Directed part at the reset settings (threshold 1, one step per inference).
        // Feature 0 gets the extreme weights so its membranes wrap.
        queue_request(sfi_pkg::OP_WEIGHT, $urandom, 0, 0, 32'h7FFF_FFFF);
        queue_request(sfi_pkg::OP_WEIGHT, $urandom, 1, 0, 32'h8000_0000);
        queue_request(sfi_pkg::OP_WEIGHT, $urandom, sfi_pkg::CLASSES - 1,
                      sfi_pkg::FEATURES - 1, 32'hFFFF_FFFF);
        // A class row past the layer must leave every weight alone.
        queue_request(sfi_pkg::OP_WEIGHT, '1, 32'd15, 32'd5, 32'h1234_5678);
        queue_words(32'h0000_0001, '0, '0, '0);
        queue_words(SPIKE_FEATURES, SPIKE_FEATURES, SPIKE_FEATURES, SPIKE_FEATURES);
        queue_words('0, '0, '0, 32'h8000_0000);
        queue_request(OP_UNUSED, '1, '1, '1, '1);
        // A step cut short by a clear restarts at word zero.
        queue_request(sfi_pkg::OP_SPIKE, SPIKE_FEATURES, '0, '0, '0);
        queue_request(sfi_pkg::OP_SPIKE, 32'hA5A5_A5A5 & SPIKE_FEATURES, '0, '0, '0);
        queue_request(sfi_pkg::OP_CLEAR, '0, '0, '0, '0);
        queue_words('0, '0, '0, '0);
        wait_for_results(SETTLE_CYCLES);

        // Phases: both threshold extremes, zero and maximum step counts, then random
        // settings. One phase runs with no throttling on either side.
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    thr = 32'h8000_0000;
                    steps = 32'd3;
                end
                1: begin
                    thr = 32'h7FFF_FFFF;
                    steps = 32'd1;
                end
                2: begin
                    thr = 32'd0;
                    steps = 32'd0;
                end
                3: begin
                    thr = 32'd2000;
                    steps = {16'($urandom_range(16'hFFFF)), 16'hFFFF};
                end
                default: begin
                    thr = $urandom_range(6500) - 500;
                    steps = {16'($urandom_range(16'hFFFF)), 16'($urandom_range(1, 7))};
                end
            endcase
            write_config(sfi_pkg::CFG_THRESHOLD, thr);
            write_config(sfi_pkg::CFG_STEPS, steps);
            idle_enable = (p != 5);
            // The sender holds back halfway until every mask of the first half is in.
            queue_random_mix(MIX_ITEMS / 2);
            wait_for_results(0);
            queue_random_mix(MIX_ITEMS / 2);
            wait_for_results(SETTLE_CYCLES);
        end

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
